FILE: design/triangle_barycentric_projection_core_macros.svh
// Assertion macros shared by the checker of the barycentric projection core
`ifndef TRIANGLE_BARYCENTRIC_PROJECTION_CORE_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_PROJECTION_CORE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TBP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define TBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: design/tbp_pkg.sv
// Types and widths shared by the barycentric projection core
package tbp_pkg;

    localparam int COORD_BITS = 32;
    localparam int AXES       = 3;
    localparam int LANES      = 3;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int CROSS_W    = 2 * DIFF_W + 1;
    localparam int DOT_W      = 2 * CROSS_W + 2;
    localparam int NUM_W      = DOT_W + 2;
    localparam int LIMB_W     = 32;
    localparam int MUL_LAT    = 5;
    localparam int GEOM_LAT   = 2 * MUL_LAT + 4;
    localparam int DIV_LAT    = COORD_BITS + 5;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DOT_W-1:0]      t_dot;

    typedef struct packed {
        t_coord query_x;
        t_coord query_y;
        t_coord query_z;
        t_coord first_x;
        t_coord first_y;
        t_coord first_z;
        t_coord second_x;
        t_coord second_y;
        t_coord second_z;
        t_coord third_x;
        t_coord third_y;
        t_coord third_z;
    } t_query_in;

    typedef struct packed {
        t_coord weight_first;
        t_coord weight_second;
        t_coord weight_third;
        logic   degenerate;
    } t_weight_out;

    typedef struct packed {
        t_dot den;
        t_dot num_second;
        t_dot num_third;
    } t_dots;

endpackage

FILE: design/tbp_mul.sv
// Pipelined signed multiplier built from 32x32 partial products
module tbp_mul
    import tbp_pkg::*;
#(
    parameter int AW = 33
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [AW-1:0]    i_b,
    output logic signed [2*AW-1:0]  o_p
);

    localparam int L   = (AW + LIMB_W - 1) / LIMB_W;
    localparam int MW  = L * LIMB_W;
    localparam int PW  = 2 * MW;
    localparam int PPW = 2 * LIMB_W;
    localparam int CW  = LIMB_W + $clog2(2 * L) + 1;
    localparam int CCW = CW - LIMB_W;
    localparam int SW  = PW + LIMB_W;

    logic [AW-1:0]          abs_a;
    logic [AW-1:0]          abs_b;
    logic [MW-1:0]          r_mag_a;
    logic [MW-1:0]          r_mag_b;
    logic                   r_neg_s1;
    logic [PPW-1:0]         r_pp [L][L];
    logic                   r_neg_s2;
    logic [CW-1:0]          n_col [2*L];
    logic [CW-1:0]          r_col [2*L];
    logic                   r_neg_s3;
    logic [SW-1:0]          sum_lo;
    logic [SW-1:0]          sum_hi;
    logic [PW-1:0]          r_mag_p;
    logic                   r_neg_s4;
    logic signed [2*AW-1:0] r_p;

    assign abs_a = i_a[AW-1] ? AW'(~i_a + 1'b1) : AW'(i_a);
    assign abs_b = i_b[AW-1] ? AW'(~i_b + 1'b1) : AW'(i_b);

    always_comb begin
        for (int k = 0; k < 2 * L; k++) begin
            n_col[k] = '0;
        end
        for (int i = 0; i < L; i++) begin
            for (int j = 0; j < L; j++) begin
                n_col[i+j]   = n_col[i+j] + CW'(r_pp[i][j][LIMB_W-1:0]);
                n_col[i+j+1] = n_col[i+j+1] + CW'(r_pp[i][j][PPW-1:LIMB_W]);
            end
        end
    end

    always_comb begin
        sum_lo = '0;
        sum_hi = '0;
        for (int k = 0; k < 2 * L; k++) begin
            sum_lo[k*LIMB_W +: LIMB_W]   = r_col[k][LIMB_W-1:0];
            sum_hi[(k+1)*LIMB_W +: CCW]  = r_col[k][CW-1:LIMB_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_a  <= MW'(abs_a);
            r_mag_b  <= MW'(abs_b);
            r_neg_s1 <= i_a[AW-1] ^ i_b[AW-1];
            for (int i = 0; i < L; i++) begin
                for (int j = 0; j < L; j++) begin
                    r_pp[i][j] <= PPW'(r_mag_a[i*LIMB_W +: LIMB_W])
                                * PPW'(r_mag_b[j*LIMB_W +: LIMB_W]);
                end
            end
            r_neg_s2 <= r_neg_s1;
            r_col    <= n_col;
            r_neg_s3 <= r_neg_s2;
            r_mag_p  <= PW'(sum_lo + sum_hi);
            r_neg_s4 <= r_neg_s3;
            r_p      <= r_neg_s4 ? (2*AW)'(~r_mag_p + 1'b1) : (2*AW)'(r_mag_p);
        end
    end

    assign o_p = r_p;

endmodule

FILE: design/tbp_geom.sv
// Edge vectors, cross products and dot products of one query
module tbp_geom
    import tbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_query_in i_data,
    output logic      o_valid,
    output t_dots     o_dots
);

    localparam int AXIS_X    = 0;
    localparam int AXIS_Y    = 1;
    localparam int AXIS_Z    = 2;
    localparam int CR_NORMAL = 0;
    localparam int CR_THIRD  = 1;
    localparam int CR_SECOND = 2;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DPROD_W   = 2 * CROSS_W;

    t_coord                    pt [AXES];
    t_coord                    va [AXES];
    t_coord                    vb [AXES];
    t_coord                    vc [AXES];
    logic signed [DIFF_W-1:0]  r_u [AXES];
    logic signed [DIFF_W-1:0]  r_v [AXES];
    logic signed [DIFF_W-1:0]  r_w [AXES];
    logic signed [DIFF_W-1:0]  op_a [LANES][AXES];
    logic signed [DIFF_W-1:0]  op_b [LANES][AXES];
    logic signed [PROD_W-1:0]  cp_pos [LANES][AXES];
    logic signed [PROD_W-1:0]  cp_neg [LANES][AXES];
    logic signed [CROSS_W-1:0] r_cr [LANES][AXES];
    logic signed [DPROD_W-1:0] dp [LANES][AXES];
    logic signed [DOT_W-1:0]   r_pair [LANES];
    logic signed [DPROD_W-1:0] r_last [LANES];
    logic signed [DOT_W-1:0]   r_dot [LANES];
    logic [GEOM_LAT-1:0]       r_valid;

    assign pt[AXIS_X] = i_data.query_x;
    assign pt[AXIS_Y] = i_data.query_y;
    assign pt[AXIS_Z] = i_data.query_z;
    assign va[AXIS_X] = i_data.first_x;
    assign va[AXIS_Y] = i_data.first_y;
    assign va[AXIS_Z] = i_data.first_z;
    assign vb[AXIS_X] = i_data.second_x;
    assign vb[AXIS_Y] = i_data.second_y;
    assign vb[AXIS_Z] = i_data.second_z;
    assign vc[AXIS_X] = i_data.third_x;
    assign vc[AXIS_Y] = i_data.third_y;
    assign vc[AXIS_Z] = i_data.third_z;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            op_a[CR_NORMAL][k] = r_u[k];
            op_b[CR_NORMAL][k] = r_v[k];
            op_a[CR_THIRD][k]  = r_u[k];
            op_b[CR_THIRD][k]  = r_w[k];
            op_a[CR_SECOND][k] = r_w[k];
            op_b[CR_SECOND][k] = r_v[k];
        end
    end

    for (genvar c = 0; c < LANES; c++) begin : g_cross
        for (genvar k = 0; k < AXES; k++) begin : g_axis
            tbp_mul #(.AW(DIFF_W)) u_mul_pos (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_a   (op_a[c][(k+1)%AXES]),
                .i_b   (op_b[c][(k+2)%AXES]),
                .o_p   (cp_pos[c][k])
            );
            tbp_mul #(.AW(DIFF_W)) u_mul_neg (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_a   (op_a[c][(k+2)%AXES]),
                .i_b   (op_b[c][(k+1)%AXES]),
                .o_p   (cp_neg[c][k])
            );
            tbp_mul #(.AW(CROSS_W)) u_mul_dot (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_a   (r_cr[c][k]),
                .i_b   (r_cr[CR_NORMAL][k]),
                .o_p   (dp[c][k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < AXES; k++) begin
                r_u[k] <= DIFF_W'(vb[k]) - DIFF_W'(va[k]);
                r_v[k] <= DIFF_W'(vc[k]) - DIFF_W'(va[k]);
                r_w[k] <= DIFF_W'(pt[k]) - DIFF_W'(va[k]);
            end
            for (int c = 0; c < LANES; c++) begin
                for (int k = 0; k < AXES; k++) begin
                    r_cr[c][k] <= CROSS_W'(cp_pos[c][k]) - CROSS_W'(cp_neg[c][k]);
                end
                r_pair[c] <= DOT_W'(dp[c][AXIS_X]) + DOT_W'(dp[c][AXIS_Y]);
                r_last[c] <= dp[c][AXIS_Z];
                r_dot[c]  <= r_pair[c] + DOT_W'(r_last[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[GEOM_LAT-2:0], i_valid};
        end
    end

    assign o_valid           = r_valid[GEOM_LAT-1];
    assign o_dots.den        = r_dot[CR_NORMAL];
    assign o_dots.num_third  = r_dot[CR_THIRD];
    assign o_dots.num_second = r_dot[CR_SECOND];

endmodule

FILE: design/tbp_div.sv
// Three-lane pipelined restoring divider with rounding and saturation
module tbp_div
    import tbp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_dots       i_dots,
    output logic        o_valid,
    output t_weight_out o_data
);

    localparam int LANE_FIRST  = 0;
    localparam int LANE_SECOND = 1;
    localparam int LANE_THIRD  = 2;
    localparam int STEPS       = COORD_BITS;
    localparam int MAG_W       = DOT_W + FRAC_BITS + COORD_BITS + 4;
    localparam logic [COORD_BITS-1:0] SAT_HIGH = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] SAT_LOW  = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [NUM_W-1:0] r_num [LANES];
    logic [DOT_W-1:0]        r_den1;
    logic                    r_deg1;
    logic [NUM_W-1:0]        r_abs [LANES];
    logic                    r_neg2 [LANES];
    logic [DOT_W-1:0]        r_den2;
    logic                    r_deg2;
    logic [MAG_W-1:0]        r_mag [LANES];
    logic                    r_neg3 [LANES];
    logic [MAG_W-1:0]        r_dd;
    logic                    r_deg3;
    logic [MAG_W-1:0]        r_rem [STEPS+1][LANES];
    logic [COORD_BITS-1:0]   r_q [STEPS+1][LANES];
    logic                    r_sat [STEPS+1][LANES];
    logic                    r_neg [STEPS+1][LANES];
    logic [MAG_W-1:0]        r_dd_st [STEPS+1];
    logic                    r_deg [STEPS+1];
    logic [COORD_BITS-1:0]   n_w [LANES];
    logic [COORD_BITS-1:0]   r_w [LANES];
    logic                    r_deg_out;
    logic [DIV_LAT-1:0]      r_valid;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[LANE_FIRST]  <= NUM_W'(i_dots.den) - NUM_W'(i_dots.num_third)
                                - NUM_W'(i_dots.num_second);
            r_num[LANE_SECOND] <= NUM_W'(i_dots.num_second);
            r_num[LANE_THIRD]  <= NUM_W'(i_dots.num_third);
            r_den1 <= i_dots.den;
            r_deg1 <= (i_dots.den == '0);
            for (int l = 0; l < LANES; l++) begin
                r_abs[l]  <= r_num[l][NUM_W-1] ? NUM_W'(~r_num[l] + 1'b1) : NUM_W'(r_num[l]);
                r_neg2[l] <= r_num[l][NUM_W-1];
                r_mag[l]  <= (MAG_W'(r_abs[l]) << (FRAC_BITS + 1)) + MAG_W'(r_den2);
                r_neg3[l] <= r_neg2[l];
            end
            r_den2 <= r_den1;
            r_deg2 <= r_deg1;
            r_dd   <= MAG_W'(r_den2) << 1;
            r_deg3 <= r_deg2;
        end
    end

    for (genvar s = 0; s <= STEPS; s++) begin : g_step
        if (s == 0) begin : g_load
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_rem[0][l] <= r_mag[l];
                        r_q[0][l]   <= '0;
                        r_sat[0][l] <= (r_mag[l] >> COORD_BITS) >= r_dd;
                        r_neg[0][l] <= r_neg3[l];
                    end
                    r_dd_st[0] <= r_dd;
                    r_deg[0]   <= r_deg3;
                end
            end
        end else begin : g_iter
            localparam int BIT = STEPS - s;
            logic [MAG_W-1:0] trial;

            assign trial = r_dd_st[s-1] << BIT;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int l = 0; l < LANES; l++) begin
                        if (r_rem[s-1][l] >= trial) begin
                            r_rem[s][l] <= r_rem[s-1][l] - trial;
                            r_q[s][l]   <= r_q[s-1][l] | (COORD_BITS'(1) << BIT);
                        end else begin
                            r_rem[s][l] <= r_rem[s-1][l];
                            r_q[s][l]   <= r_q[s-1][l];
                        end
                        r_sat[s][l] <= r_sat[s-1][l];
                        r_neg[s][l] <= r_neg[s-1][l];
                    end
                    r_dd_st[s] <= r_dd_st[s-1];
                    r_deg[s]   <= r_deg[s-1];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (r_deg[STEPS]) begin
                n_w[l] = '0;
            end else if (r_sat[STEPS][l]) begin
                n_w[l] = r_neg[STEPS][l] ? SAT_LOW : SAT_HIGH;
            end else if (r_neg[STEPS][l]) begin
                n_w[l] = (r_q[STEPS][l] > SAT_LOW) ? SAT_LOW
                                                   : COORD_BITS'(~r_q[STEPS][l] + 1'b1);
            end else begin
                n_w[l] = (r_q[STEPS][l] > SAT_HIGH) ? SAT_HIGH : r_q[STEPS][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w       <= n_w;
            r_deg_out <= r_deg[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIV_LAT-2:0], i_valid};
        end
    end

    assign o_valid              = r_valid[DIV_LAT-1];
    assign o_data.weight_first  = r_w[LANE_FIRST];
    assign o_data.weight_second = r_w[LANE_SECOND];
    assign o_data.weight_third  = r_w[LANE_THIRD];
    assign o_data.degenerate    = r_deg_out;

endmodule

FILE: design/triangle_barycentric_projection_core.sv
// Top level of the barycentric projection core: pipeline, output register and skid stage
//
// Channel   Handshake                   Payload
// input     i_in_valid / o_in_ready     i_in_data  (t_query_in)
// output    o_out_valid / i_out_ready   o_out_data (t_weight_out)
//
// One query per cycle while o_in_ready is high; the result is registered at the output.
// Latency is set by two 5-stage multiplier passes and the 32-step divider pipeline.
// Reset clears valid bits only; data registers load freely.
// A stalled output parks one more transfer in the skid stage, then o_in_ready drops
// and the whole pipeline holds until the output transfer completes.
module triangle_barycentric_projection_core
    import tbp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_query_in   i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_weight_out o_out_data
);

    logic        en;
    logic        take;
    logic        geom_valid;
    t_dots       geom_dots;
    logic        div_valid;
    t_weight_out div_data;
    logic        r_out_valid;
    t_weight_out r_out;
    logic        r_skid_valid;
    t_weight_out r_skid;

    assign en   = !r_skid_valid;
    assign take = r_out_valid && i_out_ready;

    tbp_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (geom_valid),
        .o_dots  (geom_dots)
    );

    tbp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (geom_valid),
        .i_dots  (geom_dots),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (div_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (div_valid) begin
            if (!r_out_valid || take) begin
                r_out <= div_data;
            end else begin
                r_skid <= div_data;
            end
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/tbp_checker.sv
// Port-level checks for the barycentric projection core, bound to the top level
`include "triangle_barycentric_projection_core_macros.svh"
module tbp_checker
    import tbp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_weight_out o_out_data
);

    logic weights_zero;

    assign weights_zero = (o_out_data.weight_first == '0) && (o_out_data.weight_second == '0)
                       && (o_out_data.weight_third == '0);

    `TBP_ASSERT_IMPLIES(a_degenerate_zero, o_out_valid && o_out_data.degenerate, weights_zero)
    `TBP_ASSERT_NEXT(a_idle_out_ready, !o_out_valid, o_in_ready)
    `TBP_ASSERT_IMPLIES(a_ready_drop_cause, $fell(o_in_ready), $past(o_out_valid && !i_out_ready))
    `TBP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind triangle_barycentric_projection_core tbp_checker u_tbp_checker (.*);
